// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define QP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never be true outside reset.
`define QP_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// ===== hdl/qpgl_pkg.sv =====
// Types and constants for the quad pad grid point lookup block.
`default_nettype none

package qpgl_pkg;

	localparam int MAX_SIDE   = 32;
	localparam int COORD_BITS = 20;
	localparam int PAD_SLOTS  = MAX_SIDE * MAX_SIDE;
	localparam int AW         = $clog2(PAD_SLOTS);
	localparam int SIDE_W     = $clog2(MAX_SIDE);
	localparam int CNT_W      = $clog2(MAX_SIDE + 1);
	localparam int MUL_W      = COORD_BITS + 2;
	localparam int PROD_W     = 2 * MUL_W;

	// Fixed field widths of the ports
	localparam int CFG_W = 6;
	localparam int IDX_W = 10;
	localparam int RC_W  = 5;

	// Register indexes
	localparam logic REG_PADS_ACROSS = 1'b0;
	localparam logic REG_PADS_DOWN   = 1'b1;

	// Request types
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} corner_t;

	typedef struct packed {
		corner_t ld;
		corner_t lu;
		corner_t rd;
		corner_t ru;
	} pad_t;

	typedef struct packed {
		logic             req_type;
		logic [IDX_W-1:0] pad_index;
		coord_t           left_down_x;
		coord_t           left_down_y;
		coord_t           left_up_x;
		coord_t           left_up_y;
		coord_t           right_down_x;
		coord_t           right_down_y;
		coord_t           right_up_x;
		coord_t           right_up_y;
		coord_t           query_x;
		coord_t           query_y;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] hit_index;
		logic [RC_W-1:0]  pad_row;
		logic [RC_W-1:0]  pad_col;
	} result_t;

	// Control of the shared side unit
	typedef struct packed {
		logic col_mode;  // 0: top/bottom edges, 1: left/right edges
		logic edge_sel;  // which edge of the pair
		logic ld_lhs;    // capture (y - a.y) * dx
		logic ld_rhs;    // capture dy * (x - a.x)
	} side_ctrl_t;

	typedef struct packed {
		logic gt;  // point above the line
		logic lt;  // point below the line
	} side_res_t;

endpackage

`default_nettype wire

// ===== hdl/quad_pad_grid_point_lookup_top.sv =====
// Quad pad grid point lookup: pad store, scan sequencer and result register.
//
// A load (req_type 0) writes one pad's corners in the cycle it is accepted and
// leaves busy low. A query (req_type 1) raises busy and scans the first pad of
// each row, then the pads of the first matching row. Each pad tested takes one
// store read and four products on the single shared multiplier, the last
// compare ending in the decision. With an empty grid no pad is tested. The
// result is shown on result for one cycle with result_valid high, in the
// cycle busy falls; the receiver cannot stall it.
// The corner store is not cleared at reset: a query must only reach pads
// that were loaded.
`default_nettype none

module quad_pad_grid_point_lookup_top import qpgl_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire req_t             req,
	output logic                  result_valid,
	output result_t               result,
	input  wire logic             wr_en,
	input  wire logic             wr_index,
	input  wire logic [CFG_W-1:0] wr_data
);

`include "assert_macros.svh"

	typedef enum logic [2:0] {
		ST_IDLE, ST_ADDR, ST_L0, ST_R0, ST_L1, ST_R1, ST_DEC, ST_FIN
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  pads_across_q, pads_down_q;
	logic [CNT_W-1:0]  across_c, down_c;
	logic [SIDE_W-1:0] scan_row_q, scan_col_q;
	logic [AW-1:0]     base_q, rd_addr;
	logic              col_mode_q;
	coord_t            qx_q, qy_q;
	logic              s0_gt_q, s0_lt_q;
	pad_t              mem [PAD_SLOTS];
	pad_t              pad_q;
	pad_t              wr_pad;
	side_ctrl_t        sctrl;
	side_res_t         sres;
	logic              simple_out, e0_en, e1_en, e0_out, e1_out, sp0, sp1, outside;
	logic              last_row, last_col;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pads_across_q <= CFG_W'(32);
			pads_down_q   <= CFG_W'(32);
		end else if (wr_en) begin
			case (wr_index)
				REG_PADS_ACROSS: pads_across_q <= wr_data;
				REG_PADS_DOWN:   pads_down_q   <= wr_data;
				default:         pads_across_q <= pads_across_q;
			endcase
		end
	end

	// Saturate at the grid size
	always_comb begin
		if (32'(pads_across_q) > MAX_SIDE) across_c = CNT_W'(MAX_SIDE);
		else across_c = CNT_W'(pads_across_q);
		if (32'(pads_down_q) > MAX_SIDE) down_c = CNT_W'(MAX_SIDE);
		else down_c = CNT_W'(pads_down_q);
	end

	assign rd_addr = base_q + AW'(scan_col_q);
	assign wr_pad  = '{ld: '{req.left_down_x, req.left_down_y},
	                   lu: '{req.left_up_x, req.left_up_y},
	                   rd: '{req.right_down_x, req.right_down_y},
	                   ru: '{req.right_up_x, req.right_up_y}};

	// Corner store
	always_ff @(posedge clk) begin
		if (start && !busy && req.req_type == REQ_LOAD
				&& 32'(req.pad_index) < PAD_SLOTS) begin
			mem[AW'(req.pad_index)] <= wr_pad;
		end
		if (state_q == ST_ADDR) begin
			pad_q <= mem[rd_addr];
		end
	end

	// Shared side unit control
	always_comb begin
		sctrl.col_mode = col_mode_q;
		sctrl.edge_sel = (state_q == ST_L1) || (state_q == ST_R1);
		sctrl.ld_lhs   = (state_q == ST_L0) || (state_q == ST_L1);
		sctrl.ld_rhs   = (state_q == ST_R0) || (state_q == ST_R1);
	end

	qpgl_side_unit u_side (
		.clk  (clk),
		.pad  (pad_q),
		.qx   (qx_q),
		.qy   (qy_q),
		.ctrl (sctrl),
		.res  (sres)
	);

	// Pad decision: plain edge checks plus the two line tests
	always_comb begin
		sp0 = 1'b0;
		sp1 = 1'b0;
		if (!col_mode_q) begin
			simple_out = (pad_q.lu.y == pad_q.ru.y && qy_q > pad_q.lu.y)
			          || (pad_q.rd.y == pad_q.ld.y && qy_q < pad_q.rd.y)
			          || (pad_q.rd.x == pad_q.ld.x && qx_q < pad_q.rd.x)
			          || (pad_q.lu.x == pad_q.ru.x && qx_q > pad_q.lu.x);
			e0_en  = pad_q.lu.x != pad_q.ru.x;
			e1_en  = pad_q.ld.x != pad_q.rd.x;
			e0_out = s0_gt_q;
			e1_out = sres.lt;
		end else begin
			simple_out = (pad_q.ld.x == pad_q.lu.x && qx_q < pad_q.ld.x)
			          || (pad_q.ld.y == pad_q.lu.y && qy_q < pad_q.ld.y)
			          || (pad_q.ru.x == pad_q.rd.x && qx_q > pad_q.ru.x)
			          || (pad_q.ru.y == pad_q.rd.y && qy_q > pad_q.ru.y);
			e0_en  = pad_q.ld.x != pad_q.lu.x;
			e1_en  = pad_q.ru.x != pad_q.rd.x;
			// positive slope: same sign of dx and dy, both nonzero
			sp0 = (pad_q.ld.y != pad_q.lu.y) && e0_en
			   && ((pad_q.lu.y > pad_q.ld.y) == (pad_q.lu.x > pad_q.ld.x));
			sp1 = (pad_q.ru.y != pad_q.rd.y) && e1_en
			   && ((pad_q.rd.y > pad_q.ru.y) == (pad_q.rd.x > pad_q.ru.x));
			e0_out = sp0 ? s0_gt_q : s0_lt_q;
			e1_out = sp1 ? sres.lt : sres.gt;
		end
		outside  = simple_out || (e0_en && e0_out) || (e1_en && e1_out);
		last_row = (CNT_W'(scan_row_q) + CNT_W'(1)) == down_c;
		last_col = (CNT_W'(scan_col_q) + CNT_W'(1)) == across_c;
	end

	// Scan sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_row_q   <= '0;
			scan_col_q   <= '0;
			base_q       <= '0;
			col_mode_q   <= 1'b0;
			result_valid <= 1'b0;
			result       <= '0;
			qx_q         <= '0;
			qy_q         <= '0;
			s0_gt_q      <= 1'b0;
			s0_lt_q      <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start && req.req_type == REQ_QUERY) begin
						qx_q       <= req.query_x;
						qy_q       <= req.query_y;
						scan_row_q <= '0;
						scan_col_q <= '0;
						base_q     <= '0;
						col_mode_q <= 1'b0;
						if (across_c == '0 || down_c == '0) state_q <= ST_FIN;
						else state_q <= ST_ADDR;
					end
				end
				ST_ADDR: state_q <= ST_L0;
				ST_L0:   state_q <= ST_R0;
				ST_R0:   state_q <= ST_L1;
				ST_L1: begin
					s0_gt_q <= sres.gt;
					s0_lt_q <= sres.lt;
					state_q <= ST_R1;
				end
				ST_R1:   state_q <= ST_DEC;
				ST_DEC: begin
					if (!col_mode_q) begin
						if (!outside) begin
							col_mode_q <= 1'b1;
							state_q    <= ST_ADDR;
						end else if (last_row) begin
							result_valid <= 1'b1;
							result       <= '0;
							state_q      <= ST_IDLE;
						end else begin
							scan_row_q <= scan_row_q + SIDE_W'(1);
							base_q     <= base_q + AW'(across_c);
							state_q    <= ST_ADDR;
						end
					end else begin
						if (!outside) begin
							result_valid      <= 1'b1;
							result.found      <= 1'b1;
							result.hit_index  <= IDX_W'(rd_addr);
							result.pad_row    <= RC_W'(scan_row_q);
							result.pad_col    <= RC_W'(scan_col_q);
							state_q           <= ST_IDLE;
						end else if (last_col) begin
							result_valid <= 1'b1;
							result       <= '0;
							state_q      <= ST_IDLE;
						end else begin
							scan_col_q <= scan_col_q + SIDE_W'(1);
							state_q    <= ST_ADDR;
						end
					end
				end
				ST_FIN: begin
					result_valid <= 1'b1;
					result       <= '0;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = state_q != ST_IDLE;

	`QP_ASSERT(a_res_single, result_valid |=> !result_valid, "result strobe held two cycles")
	`QP_ASSERT(a_miss_zero, result_valid && !result.found |-> (result.hit_index == '0) && (result.pad_row == '0) && (result.pad_col == '0), "miss with nonzero fields")
	`QP_ASSERT(a_query_busy, start && !busy && req.req_type == REQ_QUERY |=> busy, "query transfer did not raise busy")
	`QP_ASSERT_NEVER(a_col_range, result_valid && result.found && (CNT_W'(result.pad_col) >= across_c), "hit column beyond grid")

endmodule

`default_nettype wire

// ===== hdl/qpgl_side_unit.sv =====
// Shared multiply and compare unit: which side of a pad edge a point lies on.
`default_nettype none

module qpgl_side_unit import qpgl_pkg::*; (
	input  wire logic       clk,
	input  wire pad_t       pad,
	input  wire coord_t     qx,
	input  wire coord_t     qy,
	input  wire side_ctrl_t ctrl,
	output side_res_t       res
);

	corner_t a;
	corner_t b;
	logic signed [COORD_BITS:0] dx, dy, ex, ey;
	logic signed [MUL_W-1:0]    dxw, dyw, dxn, dyn, exw, eyw, op_a, op_b;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   lhs_q, rhs_q;

	// Edge endpoints
	always_comb begin
		case ({ctrl.col_mode, ctrl.edge_sel})
			2'b00:   begin a = pad.lu; b = pad.ru; end
			2'b01:   begin a = pad.ld; b = pad.rd; end
			2'b10:   begin a = pad.ld; b = pad.lu; end
			2'b11:   begin a = pad.ru; b = pad.rd; end
			default: begin a = pad.lu; b = pad.ru; end
		endcase
	end

	// Differences, direction normalized to positive dx
	always_comb begin
		dx  = {b.x[COORD_BITS-1], b.x} - {a.x[COORD_BITS-1], a.x};
		dy  = {b.y[COORD_BITS-1], b.y} - {a.y[COORD_BITS-1], a.y};
		ex  = {qx[COORD_BITS-1], qx} - {a.x[COORD_BITS-1], a.x};
		ey  = {qy[COORD_BITS-1], qy} - {a.y[COORD_BITS-1], a.y};
		dxw = {dx[COORD_BITS], dx};
		dyw = {dy[COORD_BITS], dy};
		exw = {ex[COORD_BITS], ex};
		eyw = {ey[COORD_BITS], ey};
		dxn = dx[COORD_BITS] ? -dxw : dxw;
		dyn = dx[COORD_BITS] ? -dyw : dyw;
		op_a = ctrl.ld_lhs ? eyw : dyn;
		op_b = ctrl.ld_lhs ? dxn : exw;
		prod = op_a * op_b;
	end

	// Product registers
	always_ff @(posedge clk) begin
		if (ctrl.ld_lhs) begin
			lhs_q <= prod;
		end
		if (ctrl.ld_rhs) begin
			rhs_q <= prod;
		end
	end

	assign res = '{gt: lhs_q > rhs_q, lt: lhs_q < rhs_q};

endmodule

`default_nettype wire
